// File: src/swfd_pkg.sv
// Package with shared constants, codes and the CRC-32 byte step for the sync-word deframer.
`timescale 1ns / 1ps
package swfd_pkg;

    localparam int unsigned MaxPayloadDefault = 128;
    localparam int unsigned HeaderBytes       = 36;

    localparam logic [15:0] VersionReset  = 16'h0001;
    localparam logic [31:0] SyncWordReset = 32'h314f_5441;
    localparam logic [31:0] CrcPoly       = 32'hedb8_8320;
    localparam logic [31:0] AllOnes       = 32'hffff_ffff;

    // Header byte positions (the sync word takes positions 0..3)
    localparam int unsigned PosType   = 6;
    localparam int unsigned PosSeq    = 8;
    localparam int unsigned PosObject = 12;
    localparam int unsigned PosOffset = 16;
    localparam int unsigned PosStatus = 20;
    localparam int unsigned PosValue  = 24;
    localparam int unsigned PosLength = 28;
    localparam int unsigned PosCrc    = 32;

    localparam int unsigned OutDataW = 224;

    typedef enum logic [2:0] {
        PH_HUNT    = 3'b001,
        PH_HEADER  = 3'b010,
        PH_PAYLOAD = 3'b100
    } t_phase;

    typedef enum logic [2:0] {
        VERDICT_OK       = 3'd0,
        VERDICT_VERSION  = 3'd1,
        VERDICT_LONG     = 3'd2,
        VERDICT_CRC      = 3'd3,
        VERDICT_OVERFLOW = 3'd4
    } t_verdict;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_VERDICT = 1'b1
    } t_kind;

    typedef enum logic {
        REG_VERSION = 1'b0,
        REG_SYNC    = 1'b1
    } t_reg_sel;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc_in ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

// File: src/sync_word_frame_deframer_crc32_unit.sv
// Sync-word frame deframer with header capture and CRC-32 payload check.
//
// Input stream: one received byte per transaction on i_s_tdata, with the
// ring-overflow flag on i_s_tuser. A set flag aborts a frame in progress
// (verdict overflow) or clears the sync window while hunting.
// Output stream: o_m_tuser gives the kind (0 payload byte, 1 verdict);
// o_m_tdata carries the payload byte, the captured header fields and the
// verdict code. Payload bytes are forwarded as they arrive; the caller drops
// them when the closing verdict is not ok.
// Throughput: one input byte per cycle while o_s_tready is high. Each byte is
// fully handled in the cycle it is accepted (byte-wide CRC step, field capture);
// its result, if any, is registered in the output buffer and shown on o_m_tvalid.
// Stall: a two-entry output buffer (output register plus skid register)
// decouples the sides; o_s_tready drops only when both entries hold results.
// Config: APB writes to expected version (0x0) and sync word (0x4); the user must do
// them only while the block is idle, which the block itself does not enforce.
// Reset (synchronous, active low): hunt for sync, window cleared, no result
// pending, registers back to version 1 and the default sync word.
`timescale 1ns / 1ps
module sync_word_frame_deframer_crc32_unit #(
    parameter int unsigned MAX_PAYLOAD = swfd_pkg::MaxPayloadDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // APB configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // input stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [7:0]                    i_s_tdata,   // [7:0] rx_byte
    input  logic                          i_s_tuser,   // [0] ring_overflow
    // output stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [7:0] data_byte, [23:8] frame_type, [55:24] sequence_number,
    // [87:56] object_id, [119:88] byte_offset, [151:120] status_word,
    // [183:152] value_word, [215:184] payload_length, [218:216] verdict
    output logic [swfd_pkg::OutDataW-1:0] o_m_tdata,
    output logic                          o_m_tuser    // [0] kind
);
    import swfd_pkg::*;

    localparam int unsigned CntW = ($clog2(MAX_PAYLOAD + 1) > $clog2(HeaderBytes)) ?
                                   $clog2(MAX_PAYLOAD + 1) : $clog2(HeaderBytes);

    // configuration
    logic [15:0] r_exp_version;
    logic [31:0] r_sync_word;

    // frame state
    t_phase      r_phase, n_phase;
    logic [31:0] r_window, n_window;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic [15:0] r_version, n_version;
    logic [15:0] r_type, n_type;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_object, n_object;
    logic [31:0] r_offset, n_offset;
    logic [31:0] r_status, n_status;
    logic [31:0] r_value, n_value;
    logic [31:0] r_length, n_length;
    logic [31:0] r_exp_crc, n_exp_crc;
    logic [31:0] r_crc, n_crc;
    logic        r_pend, n_pend;
    t_verdict    r_pend_code, n_pend_code;

    // output buffer
    logic                r_out_valid, r_skid_valid;
    logic [OutDataW-1:0] r_out_data, r_skid_data;
    logic                r_out_kind, r_skid_kind;

    logic                accept;
    logic                res_valid;
    t_kind               res_kind;
    logic [7:0]          res_byte;
    t_verdict            res_code;
    logic                res_blank;
    logic [OutDataW-1:0] res_data;
    logic [31:0]         crc_step;
    logic [CntW-1:0]     cnt_inc;
    logic                cfg_wr;

    assign pready     = 1'b1;
    assign cfg_wr     = psel & penable & pwrite;
    assign prdata     = (t_reg_sel'(paddr[2]) == REG_SYNC) ? r_sync_word
                                                          : {16'd0, r_exp_version};
    assign o_s_tready = ~r_skid_valid;
    assign accept     = i_s_tvalid & ~r_skid_valid;
    assign crc_step   = crc32_byte(r_crc, i_s_tdata);
    assign cnt_inc    = r_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_version <= VersionReset;
            r_sync_word   <= SyncWordReset;
        end else if (cfg_wr) begin
            case (t_reg_sel'(paddr[2]))
                REG_VERSION: r_exp_version <= pwdata[15:0];
                REG_SYNC:    r_sync_word   <= pwdata;
                default:     r_sync_word   <= r_sync_word;
            endcase
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_window    = r_window;
        n_cnt       = r_cnt;
        n_version   = r_version;
        n_type      = r_type;
        n_seq       = r_seq;
        n_object    = r_object;
        n_offset    = r_offset;
        n_status    = r_status;
        n_value     = r_value;
        n_length    = r_length;
        n_exp_crc   = r_exp_crc;
        n_crc       = r_crc;
        n_pend      = r_pend;
        n_pend_code = r_pend_code;
        res_valid   = 1'b0;
        res_kind    = KIND_PAYLOAD;
        res_byte    = 8'd0;
        res_code    = VERDICT_OK;
        res_blank   = 1'b0;

        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (i_s_tuser) begin
                        n_phase   = PH_HUNT;
                        n_window  = '0;
                        n_cnt     = '0;
                        res_valid = 1'b1;
                        res_kind  = KIND_VERDICT;
                        res_code  = VERDICT_OVERFLOW;
                        res_blank = 1'b1;
                    end else begin
                        if (r_cnt < CntW'(PosType))
                            n_version = {i_s_tdata, r_version[15:8]};
                        else if (r_cnt < CntW'(PosSeq))
                            n_type = {i_s_tdata, r_type[15:8]};
                        else if (r_cnt < CntW'(PosObject))
                            n_seq = {i_s_tdata, r_seq[31:8]};
                        else if (r_cnt < CntW'(PosOffset))
                            n_object = {i_s_tdata, r_object[31:8]};
                        else if (r_cnt < CntW'(PosStatus))
                            n_offset = {i_s_tdata, r_offset[31:8]};
                        else if (r_cnt < CntW'(PosValue))
                            n_status = {i_s_tdata, r_status[31:8]};
                        else if (r_cnt < CntW'(PosLength))
                            n_value = {i_s_tdata, r_value[31:8]};
                        else if (r_cnt < CntW'(PosCrc))
                            n_length = {i_s_tdata, r_length[31:8]};
                        else
                            n_exp_crc = {i_s_tdata, r_exp_crc[31:8]};

                        if (r_cnt != CntW'(HeaderBytes - 1)) begin
                            n_cnt = cnt_inc;
                        end else if (r_version != r_exp_version) begin
                            n_phase   = PH_HUNT;
                            n_window  = '0;
                            n_cnt     = '0;
                            res_valid = 1'b1;
                            res_kind  = KIND_VERDICT;
                            res_code  = VERDICT_VERSION;
                        end else if (r_length > 32'(MAX_PAYLOAD)) begin
                            n_phase   = PH_HUNT;
                            n_window  = '0;
                            n_cnt     = '0;
                            res_valid = 1'b1;
                            res_kind  = KIND_VERDICT;
                            res_code  = VERDICT_LONG;
                        end else begin
                            n_crc = AllOnes;
                            n_cnt = '0;
                            if (r_length == 32'd0) begin
                                // empty payload: CRC of nothing is zero
                                n_phase   = PH_HUNT;
                                n_window  = '0;
                                res_valid = 1'b1;
                                res_kind  = KIND_VERDICT;
                                res_code  = (n_exp_crc == 32'd0) ? VERDICT_OK : VERDICT_CRC;
                            end else begin
                                n_phase = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (i_s_tuser) begin
                        n_phase   = PH_HUNT;
                        n_window  = '0;
                        n_cnt     = '0;
                        res_valid = 1'b1;
                        res_kind  = KIND_VERDICT;
                        res_code  = VERDICT_OVERFLOW;
                        res_blank = 1'b1;
                    end else begin
                        n_crc     = crc_step;
                        n_cnt     = cnt_inc;
                        res_valid = 1'b1;
                        res_byte  = i_s_tdata;
                        if (32'(cnt_inc) >= r_length) begin
                            // verdict goes out with the next byte
                            n_pend      = 1'b1;
                            n_pend_code = ((crc_step ^ AllOnes) == r_exp_crc) ?
                                          VERDICT_OK : VERDICT_CRC;
                            n_phase     = PH_HUNT;
                            n_window    = '0;
                            n_cnt       = '0;
                        end
                    end
                end
                PH_HUNT: begin
                    if (r_pend) begin
                        res_valid = 1'b1;
                        res_kind  = KIND_VERDICT;
                        res_code  = r_pend_code;
                        n_pend    = 1'b0;
                    end
                    if (i_s_tuser) begin
                        n_window = '0;
                    end else begin
                        n_window = {i_s_tdata, r_window[31:8]};
                        if (n_window == r_sync_word) begin
                            n_phase = PH_HEADER;
                            n_cnt   = CntW'(4);
                        end
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        if (res_blank)
            res_data = {5'd0, res_code, 208'd0, res_byte};
        else
            res_data = {5'd0, res_code, r_length, r_value, r_status, r_offset,
                        r_object, r_seq, r_type, res_byte};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_window    <= '0;
            r_cnt       <= '0;
            r_version   <= '0;
            r_type      <= '0;
            r_seq       <= '0;
            r_object    <= '0;
            r_offset    <= '0;
            r_status    <= '0;
            r_value     <= '0;
            r_length    <= '0;
            r_exp_crc   <= '0;
            r_crc       <= AllOnes;
            r_pend      <= 1'b0;
            r_pend_code <= VERDICT_OK;
        end else begin
            r_phase     <= n_phase;
            r_window    <= n_window;
            r_cnt       <= n_cnt;
            r_version   <= n_version;
            r_type      <= n_type;
            r_seq       <= n_seq;
            r_object    <= n_object;
            r_offset    <= n_offset;
            r_status    <= n_status;
            r_value     <= n_value;
            r_length    <= n_length;
            r_exp_crc   <= n_exp_crc;
            r_crc       <= n_crc;
            r_pend      <= n_pend;
            r_pend_code <= n_pend_code;
        end
    end

    // output register plus skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_m_tready) begin
            if (r_skid_valid) begin
                r_out_data <= r_skid_data;
                r_out_kind <= r_skid_kind;
            end else begin
                r_out_data <= res_data;
                r_out_kind <= res_kind;
            end
        end else if (res_valid) begin
            r_skid_data <= res_data;
            r_skid_kind <= res_kind;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_kind;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    a_payload_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser == KIND_PAYLOAD) |-> (o_m_tdata[218:216] == VERDICT_OK))
        else $error("payload transaction carries a nonzero verdict");

    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_cnt >= CntW'(4) && r_cnt <= CntW'(HeaderBytes - 1)))
        else $error("header byte position out of range");

    a_pend_in_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_phase == PH_HUNT || r_phase == PH_HEADER))
        else $error("verdict pending while in payload");

    a_payload_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> (32'(r_cnt) < r_length))
        else $error("payload count reached length without ending frame");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the sync-word frame deframer with CRC-32 payload check.
`timescale 1ns / 1ps
module testbench;
    import swfd_pkg::*;

    localparam int unsigned MaxPay = MaxPayloadDefault;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         data;
        logic [15:0]        ftype;
        logic [31:0]        seq;
        logic [31:0]        obj;
        logic [31:0]        offs;
        logic signed [31:0] status;
        logic [31:0]        value;
        logic [31:0]        len;
        t_verdict           verdict;
    } t_frame_result;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = '0;
    logic [31:0] pwdata      = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata   = '0;   // [7:0] rx_byte
    logic        i_s_tuser   = 1'b0; // [0] ring_overflow
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b1;
    // [7:0] data_byte, [23:8] frame_type, [55:24] sequence_number,
    // [87:56] object_id, [119:88] byte_offset, [151:120] status_word,
    // [183:152] value_word, [215:184] payload_length, [218:216] verdict
    logic [OutDataW-1:0] o_m_tdata;
    logic        o_m_tuser;      // [0] kind

    sync_word_frame_deframer_crc32_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // deframer shadow state
    logic [15:0] cfg_version = VersionReset;
    logic [31:0] cfg_sync    = SyncWordReset;
    logic [31:0] win;
    t_phase      ph;
    int          cnt;
    logic [15:0] hdr_ver, hdr_type;
    logic [31:0] hdr_seq, hdr_obj, hdr_off, hdr_status, hdr_value, hdr_len;
    logic [31:0] exp_crc, run_crc;
    bit          held;
    t_verdict    held_code;

    t_frame_result deframed_q[$];

    int fail_count   = 0;
    int items_sent   = 0;
    int frames_sent  = 0;
    int results_seen = 0;
    int verdicts_seen = 0;
    int reg_writes   = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int stall_left   = 0;

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] d);
        logic [31:0] x;
        x = c ^ {24'd0, d};
        for (int k = 0; k < 8; k++)
            x = x[0] ? ((x >> 1) ^ 32'hedb8_8320) : (x >> 1);
        return x;
    endfunction

    function automatic t_frame_result make_result(input t_kind k, input logic [7:0] d,
                                                  input t_verdict v, input bit blank);
        t_frame_result r;
        r.kind    = k;
        r.data    = d;
        r.ftype   = blank ? 16'd0 : hdr_type;
        r.seq     = blank ? 32'd0 : hdr_seq;
        r.obj     = blank ? 32'd0 : hdr_obj;
        r.offs    = blank ? 32'd0 : hdr_off;
        r.status  = blank ? 32'd0 : hdr_status;
        r.value   = blank ? 32'd0 : hdr_value;
        r.len     = blank ? 32'd0 : hdr_len;
        r.verdict = v;
        return r;
    endfunction

    function automatic void close_frame();
        ph  = PH_HUNT;
        win = '0;
        cnt = 0;
    endfunction

    function automatic void deframe_reset();
        win = '0; ph = PH_HUNT; cnt = 0;
        hdr_ver = '0; hdr_type = '0; hdr_seq = '0; hdr_obj = '0; hdr_off = '0;
        hdr_status = '0; hdr_value = '0; hdr_len = '0; exp_crc = '0;
        run_crc = AllOnes; held = 1'b0; held_code = VERDICT_OK;
        cfg_version = VersionReset; cfg_sync = SyncWordReset;
    endfunction

    // Advance the shadow deframer by one accepted byte, queue what it emits.
    function automatic void deframe_byte(input logic [7:0] b, input bit ovf);
        t_verdict v;
        if (ph != PH_HUNT) begin
            if (ovf) begin
                close_frame();
                deframed_q.push_back(make_result(KIND_VERDICT, 8'd0, VERDICT_OVERFLOW, 1'b1));
                return;
            end
            if (ph == PH_HEADER) begin
                if (cnt < PosType)        hdr_ver    = {b, hdr_ver[15:8]};
                else if (cnt < PosSeq)    hdr_type   = {b, hdr_type[15:8]};
                else if (cnt < PosObject) hdr_seq    = {b, hdr_seq[31:8]};
                else if (cnt < PosOffset) hdr_obj    = {b, hdr_obj[31:8]};
                else if (cnt < PosStatus) hdr_off    = {b, hdr_off[31:8]};
                else if (cnt < PosValue)  hdr_status = {b, hdr_status[31:8]};
                else if (cnt < PosLength) hdr_value  = {b, hdr_value[31:8]};
                else if (cnt < PosCrc)    hdr_len    = {b, hdr_len[31:8]};
                else                      exp_crc    = {b, exp_crc[31:8]};
                if (cnt + 1 < HeaderBytes) begin
                    cnt++;
                    return;
                end
                run_crc = AllOnes;
                if (hdr_ver != cfg_version) begin
                    close_frame();
                    deframed_q.push_back(make_result(KIND_VERDICT, 8'd0, VERDICT_VERSION, 1'b0));
                end else if (hdr_len > MaxPay) begin
                    close_frame();
                    deframed_q.push_back(make_result(KIND_VERDICT, 8'd0, VERDICT_LONG, 1'b0));
                end else if (hdr_len == 0) begin
                    // empty payload: CRC of nothing is zero
                    v = (exp_crc == 32'd0) ? VERDICT_OK : VERDICT_CRC;
                    close_frame();
                    deframed_q.push_back(make_result(KIND_VERDICT, 8'd0, v, 1'b0));
                end else begin
                    ph  = PH_PAYLOAD;
                    cnt = 0;
                end
                return;
            end
            run_crc = crc_step(run_crc, b);
            cnt++;
            deframed_q.push_back(make_result(KIND_PAYLOAD, b, VERDICT_OK, 1'b0));
            if (cnt >= hdr_len) begin
                held_code = ((run_crc ^ AllOnes) == exp_crc) ? VERDICT_OK : VERDICT_CRC;
                held = 1'b1;
                close_frame();
            end
            return;
        end
        // hunting: a held verdict leaves with the next byte
        if (held) begin
            deframed_q.push_back(make_result(KIND_VERDICT, 8'd0, held_code, 1'b0));
            held = 1'b0;
        end
        if (ovf) begin
            win = '0;
            return;
        end
        win = {b, win[31:8]};
        if (win == cfg_sync) begin
            ph  = PH_HEADER;
            cnt = 4;
        end
    endfunction

    // receiver side: random stall bursts
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(1, 17) - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    function automatic void cmp_field(input string name, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
        if (want_v !== got_v) begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : out_check
        t_frame_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            results_seen++;
            if (deframed_q.size() == 0) begin
                $display("%0t ns: unexpected result, expected none, actual kind %0d tdata %h",
                         $time, o_m_tuser, o_m_tdata);
                fail_count++;
            end else begin
                want = deframed_q.pop_front();
                if (want.kind == KIND_VERDICT)
                    verdicts_seen++;
                cmp_field("kind",            want.kind,    o_m_tuser);
                cmp_field("data_byte",       want.data,    o_m_tdata[7:0]);
                cmp_field("frame_type",      want.ftype,   o_m_tdata[23:8]);
                cmp_field("sequence_number", want.seq,     o_m_tdata[55:24]);
                cmp_field("object_id",       want.obj,     o_m_tdata[87:56]);
                cmp_field("byte_offset",     want.offs,    o_m_tdata[119:88]);
                cmp_field("status_word",     want.status,  o_m_tdata[151:120]);
                cmp_field("value_word",      want.value,   o_m_tdata[183:152]);
                cmp_field("payload_length",  want.len,     o_m_tdata[215:184]);
                cmp_field("verdict",         want.verdict, o_m_tdata[218:216]);
            end
        end
    end

    // One byte transaction on the input stream, with an optional idle burst first.
    task automatic push_item(input logic [7:0] b, input bit ovf);
        if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= ovf;
        do @(posedge i_clk); while (!o_s_tready);
        deframe_byte(b, ovf);
        items_sent++;
    endtask

    // Bring the block to idle: end any frame or held verdict, drain all results.
    task automatic settle();
        if (ph != PH_HUNT || held)
            push_item(8'($urandom), 1'b1);
        i_s_tvalid <= 1'b0;
        while (deframed_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_reg_sel sel, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_VERSION) cfg_version = val[15:0];
        else                    cfg_sync    = val;
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] ver, input logic [31:0] sync);
        settle();
        reg_write(REG_VERSION, {16'd0, ver});
        reg_write(REG_SYNC, sync);
    endtask

    // fill: 0 random, 1 all zeros, 2 all ones (header fields and payload).
    // skip drops leading sync bytes; ovf_at flags that frame position and stops there.
    task automatic send_frame(input logic [15:0] ver, input logic [31:0] len, input bit bad_crc,
                              input int ovf_at, input int fill, input int skip);
        logic [7:0]   body [0:MaxPay-1];
        logic [31:0]  hw [0:5];
        logic [31:0]  crc;
        logic [287:0] hdr;
        logic [7:0]   b;
        int           n_pay;
        int           k;
        bit           stop;
        n_pay = (ver == cfg_version && len <= MaxPay) ? int'(len) : 0;
        for (int j = 0; j < 6; j++)
            hw[j] = (fill == 1) ? 32'd0 : (fill == 2) ? 32'hffff_ffff : $urandom;
        crc = AllOnes;
        for (int j = 0; j < n_pay; j++) begin
            body[j] = (fill == 1) ? 8'h00 : (fill == 2) ? 8'hff : 8'($urandom);
            crc = crc_step(crc, body[j]);
        end
        crc = crc ^ AllOnes;
        if (bad_crc)
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
        hdr = {crc, len, hw[5], hw[4], hw[3], hw[2], hw[1], hw[0][15:0], ver, cfg_sync};
        k = skip;
        stop = 1'b0;
        while (!stop && k < HeaderBytes + n_pay) begin
            b = (k < HeaderBytes) ? hdr[8*k +: 8] : body[k-HeaderBytes];
            push_item(b, k == ovf_at);
            stop = (k == ovf_at);
            k++;
        end
        frames_sent++;
    endtask

    task automatic test_default_frames();
        gap_pct = 20; stall_pct = 20;
        send_frame(cfg_version, 0, 1'b0, -1, 0, 0);   // empty payload, ok
        send_frame(cfg_version, 0, 1'b1, -1, 0, 0);   // empty payload, crc mismatch
        settle();
    endtask

    task automatic test_header_checks();
        send_frame(cfg_version ^ 16'h0001, 4, 1'b0, -1, 0, 0);
        // bad version wins over too long
        send_frame(cfg_version ^ 16'h8000, 32'hffff_ffff, 1'b0, -1, 0, 0);
        send_frame(cfg_version, MaxPay + 1, 1'b0, -1, 2, 0);
        settle();
    endtask

    task automatic test_overflow_cases();
        send_frame(cfg_version, 4, 1'b0, 2, 0, 0);    // overflow mid sync word
        send_frame(cfg_version, 4, 1'b0, 4, 0, 0);    // first header byte
        send_frame(cfg_version, 4, 1'b0, HeaderBytes - 1, 0, 0);
        send_frame(cfg_version, 4, 1'b0, HeaderBytes, 2, 0);
        // held verdict returned alongside an overflow while hunting
        send_frame(cfg_version, 1, 1'b1, -1, 0, 0);
        push_item(8'($urandom), 1'b1);
        settle();
    endtask

    task automatic test_config_extremes();
        set_config(16'h0000, 32'h0000_0000);
        send_frame(cfg_version, 3, 1'b0, -1, 1, 3);   // a zero byte already matches
        set_config(16'hffff, 32'hffff_ffff);
        send_frame(cfg_version, 2, 1'b0, -1, 2, 0);
        set_config(16'($urandom), 32'h4141_4141);
        push_item(8'h41, 1'b0);                       // window slides into an early match
        push_item(8'h41, 1'b0);
        send_frame(cfg_version, 1, 1'b0, -1, 0, 0);
        set_config(VersionReset, SyncWordReset);
    endtask

    task automatic test_backpressure();
        gap_pct = 0; stall_pct = 80;
        send_frame(cfg_version, MaxPay, 1'b0, -1, 0, 0);
        settle();                                     // sender holds off until drained
        stall_pct = 20; gap_pct = 20;
    endtask

    task automatic test_random_traffic();
        int          rframes;
        int          start_items;
        int          r;
        int          n_noise;
        logic [15:0] ver;
        logic [31:0] len;
        bit          bad;
        int          ovf_at;
        rframes = 0;
        start_items = items_sent;
        while (items_sent - start_items < 60 || rframes < 2) begin
            if (rframes % 2 == 1)
                set_config($urandom_range(0, 1) ? VersionReset : 16'($urandom),
                           $urandom_range(0, 1) ? SyncWordReset : $urandom);
            case ($urandom_range(0, 2))
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 15; stall_pct = 15; end
                default: begin gap_pct = 40; stall_pct = 40; end
            endcase
            n_noise = $urandom_range(0, 4);
            repeat (n_noise) push_item(8'($urandom), $urandom_range(0, 7) == 0);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, MaxPay) : $urandom_range(0, 16);
            ver = cfg_version;
            bad = 1'b0;
            ovf_at = -1;
            r = $urandom_range(0, 99);
            if (r < 10)
                bad = 1'b1;
            else if (r < 18)
                ver = cfg_version ^ 16'($urandom_range(1, 65535));
            else if (r < 25) begin
                len = $urandom;
                if (len <= MaxPay)
                    len = MaxPay + 1 + $urandom_range(0, 4000);
            end else if (r < 30)
                ovf_at = $urandom_range(0, HeaderBytes - 1 + int'(len));
            send_frame(ver, len, bad, ovf_at, 0, 0);
            rframes++;
        end
        set_config(VersionReset, SyncWordReset);
    endtask

    task automatic test_quiet_tail();
        gap_pct = 0; stall_pct = 0;
        settle();
        while (stall_left != 0) @(posedge i_clk);
        @(posedge i_clk);
        send_frame(cfg_version, $urandom_range(1, 24), $urandom_range(0, 3) == 0, -1, 0, 0);
        settle();
    endtask

    initial begin
        deframe_reset();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_default_frames();
        test_header_checks();
        test_overflow_cases();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        test_quiet_tail();
        $display("covered %0d frames in %0d input bytes, %0d results checked (%0d verdicts)",
                 frames_sent, items_sent, results_seen, verdicts_seen);
        $display("%0d register writes incl. zero and all-ones version and sync word",
                 reg_writes);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout, %0d results still expected", deframed_q.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
src/swfd_pkg.sv
src/sync_word_frame_deframer_crc32_unit.sv
tb/testbench.sv
